/* src/mdtp_pkg.sv */
// ----------------------------------------------------------------------------
// mdtp_pkg
// Shared types, character constants and type-code helpers for the method
// descriptor type packer.
// ----------------------------------------------------------------------------
package mdtp_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	// type codes
	localparam logic [3:0] CODE_VOID = 4'd1;
	localparam logic [3:0] CODE_INT  = 4'd3;
	localparam logic [3:0] CODE_LONG = 4'd5;
	localparam logic [3:0] CODE_FLT  = 4'd7;
	localparam logic [3:0] CODE_DBL  = 4'd9;
	localparam logic [3:0] CODE_REF  = 4'd11;
	localparam logic [3:0] CODE_PAD  = 4'd15;

	// descriptor characters
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_BRACK = 8'h5B;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	// register map
	localparam logic REG_OBJECT_MODE = 1'b0;

	typedef enum logic [3:0] {
		PH_OPEN  = 4'b0001,
		PH_ELEM  = 4'b0010,
		PH_ARRAY = 4'b0100,
		PH_CLASS = 4'b1000
	} phase_t;

	// one finished element, front to back
	typedef struct packed {
		logic [3:0] code;
		logic       ret;
		logic [7:0] args;
	} elem_t;

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic [3:0] prim_code(input logic [7:0] c);
		case (c)
			CH_V:    prim_code = CODE_VOID;
			CH_J:    prim_code = CODE_LONG;
			CH_F:    prim_code = CODE_FLT;
			CH_D:    prim_code = CODE_DBL;
			default: prim_code = CODE_INT;
		endcase
	endfunction

endpackage

/* src/mdtp_front.sv */
// ----------------------------------------------------------------------------
// mdtp_front
// Character parser: tracks descriptor phase and argument count, emits one
// element request per finished element.
// ----------------------------------------------------------------------------
module mdtp_front import mdtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_in,
	input  logic       object_mode,
	output logic       push,
	output elem_t      push_elem
);

	phase_t     phase_q, phase_nxt;
	logic       in_ret_q, in_ret_nxt;
	logic [7:0] args_q, args_nxt;
	logic       fin;
	logic [3:0] fin_code;
	logic [3:0] ref_code;

	assign ref_code = object_mode ? CODE_REF : CODE_INT;

	always_comb begin
		phase_nxt  = phase_q;
		in_ret_nxt = in_ret_q;
		args_nxt   = args_q;
		fin        = 1'b0;
		fin_code   = CODE_INT;
		case (phase_q)
			PH_OPEN: begin
				phase_nxt = PH_ELEM;
			end
			PH_ELEM: begin
				if (!in_ret_q && char_in == CH_RPAR) begin
					in_ret_nxt = 1'b1;
				end else begin
					if (!in_ret_q) args_nxt = sat_inc8(args_q);
					if (char_in == CH_BRACK) begin
						phase_nxt = PH_ARRAY;
					end else if (char_in == CH_L) begin
						phase_nxt = PH_CLASS;
					end else begin
						fin      = 1'b1;
						fin_code = prim_code(char_in);
					end
				end
			end
			PH_ARRAY: begin
				if (char_in == CH_L) begin
					phase_nxt = PH_CLASS;
				end else if (char_in != CH_BRACK) begin
					fin      = 1'b1;
					fin_code = ref_code;
				end
			end
			PH_CLASS: begin
				if (char_in == CH_SEMI) begin
					fin      = 1'b1;
					fin_code = ref_code;
				end
			end
			default: phase_nxt = PH_OPEN;
		endcase
		// element done: either next element or back to the opening char
		if (fin) begin
			if (in_ret_q) begin
				phase_nxt  = PH_OPEN;
				in_ret_nxt = 1'b0;
				args_nxt   = 8'd0;
			end else begin
				phase_nxt = PH_ELEM;
			end
		end
	end

	assign push           = accept && fin;
	assign push_elem.code = fin_code;
	assign push_elem.ret  = in_ret_q;
	assign push_elem.args = in_ret_q ? args_q : args_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPEN;
			in_ret_q <= 1'b0;
			args_q   <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_nxt;
			in_ret_q <= in_ret_nxt;
			args_q   <= args_nxt;
		end
	end

endmodule

/* src/mdtp_queue.sv */
// ----------------------------------------------------------------------------
// mdtp_queue
// Small FIFO of element requests between parser and packer.
// ----------------------------------------------------------------------------
module mdtp_queue import mdtp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  elem_t push_elem,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output elem_t head
);

	elem_t           mem_q [QDepth];
	logic [QAw-1:0]  wr_q, rd_q;
	logic [QAw:0]    cnt_q;

	assign full       = (cnt_q == (QAw+1)'(QDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAw+1)'(QDepth))
		else $error("queue count out of range");

endmodule

/* src/mdtp_back.sv */
// ----------------------------------------------------------------------------
// mdtp_back
// Code packer: pairs element codes into bytes, closes the descriptor with the
// last code byte (padded if unpaired) and a count, drives the result register.
// ----------------------------------------------------------------------------
module mdtp_back import mdtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  elem_t      head,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic       is_count,
	output logic [7:0] total_bytes,
	output logic       last
);

	logic       out_valid_q;
	logic [7:0] byte_q, total_q;
	logic       count_q;
	logic [3:0] held_q;
	logic       pend_q;
	logic [7:0] bytes_q;
	logic       step_q;     // pair byte of return element sent, count next
	logic       load_ok;
	logic       emit;

	assign load_ok = !out_valid_q || result_ready;

	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		if (load_ok) begin
			if (step_q) begin
				pop  = 1'b1;
				emit = 1'b1;
			end else if (head_valid) begin
				if (head.ret) begin
					emit = 1'b1;
				end else begin
					pop  = 1'b1;
					emit = pend_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (step_q) begin
				byte_q  <= head.args;
				count_q <= 1'b1;
				total_q <= sat_inc8(bytes_q);
			end else begin
				byte_q  <= pend_q ? {held_q, head.code} : {head.code, CODE_PAD};
				count_q <= 1'b0;
				total_q <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= 4'd0;
			pend_q      <= 1'b0;
			bytes_q     <= 8'd0;
			step_q      <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
			if (load_ok) begin
				if (step_q) begin
					step_q  <= 1'b0;
					held_q  <= 4'd0;
					pend_q  <= 1'b0;
					bytes_q <= 8'd0;
				end else if (head_valid) begin
					if (head.ret) begin
						step_q  <= 1'b1;
						bytes_q <= sat_inc8(bytes_q);
					end else if (pend_q) begin
						pend_q  <= 1'b0;
						bytes_q <= sat_inc8(bytes_q);
					end else begin
						held_q <= head.code;
						pend_q <= 1'b1;
					end
				end
			end
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = byte_q;
	assign is_count     = count_q;
	assign total_bytes  = total_q;
	assign last         = count_q;

	a_step_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		step_q |-> head_valid && head.ret)
		else $error("count step without return element");
	a_count_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && count_q |-> total_q != 8'd0)
		else $error("count result with zero length");
	a_step_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_q && load_ok |=> !pend_q && bytes_q == 8'd0)
		else $error("descriptor state not cleared after count");

endmodule

/* src/method_descriptor_type_packer.sv */
// ----------------------------------------------------------------------------
// method_descriptor_type_packer
// Packs the element types of a method descriptor into 4-bit code pairs.
// ----------------------------------------------------------------------------
// One descriptor character is taken per request on the char channel, up to one
// per clock unless the queue is full. The first character of each descriptor is
// dropped; each element (V=1, J=5, F=7, D=9, reference/array=11 or 3 per
// object_mode, else 3) yields a 4-bit code, and codes pair up into bytes,
// earlier code in the high nibble. A ')' makes the next element the return
// type; once it ends, the block sends the last code byte (low nibble 15 if
// unpaired) and then a count result (is_count=last=1, out_byte=argument count,
// total_bytes=code bytes + 1, both saturating at 255). A parser stage
// classifies characters and pushes one request per finished element into a
// 4-deep queue; the packer drains it into a single output register, one result
// per cycle unless result_ready stalls it. A stalled result side backs up into
// the queue before char_ready drops. object_mode (APB address 0, bit 0,
// reset 1) must only be written while the block is idle.
// ----------------------------------------------------------------------------
module method_descriptor_type_packer import mdtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// character input
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_in,
	// results
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic        is_count,
	output logic [7:0]  total_bytes,
	output logic        last
);

	logic  object_mode_q;
	logic  reg_hit;
	logic  accept;
	logic  push, pop, full, head_valid;
	elem_t push_elem, head;

	// register file: only object_mode at word 0
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_OBJECT_MODE);
	assign prdata  = reg_hit ? {31'd0, object_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && reg_hit) begin
			object_mode_q <= pwdata[0];
		end
	end

	// the parser only pushes on an accepted char, so a free queue slot is enough
	assign char_ready = !full;
	assign accept     = char_valid && char_ready;

	mdtp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_in     (char_in),
		.object_mode (object_mode_q),
		.push        (push),
		.push_elem   (push_elem)
	);

	mdtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_elem  (push_elem),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	mdtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.is_count     (is_count),
		.total_bytes  (total_bytes),
		.last         (last)
	);

endmodule
